FILE: hw/rtl/i2cbe_pkg.sv
// Shared types and constants of the I2C target bit engine.
`default_nettype none

package i2cbe_pkg;

  localparam logic       SdaAck           = 1'b0;
  localparam logic       SdaNack          = 1'b1;
  localparam logic [3:0] BitsIdle         = 4'd15;
  localparam logic [3:0] BitsAck          = 4'd8;
  localparam logic [3:0] BitsDone         = 4'd9;
  localparam logic [6:0] TargetAddrReset  = 7'd0;
  localparam logic [7:0] AddrMaskReset    = 8'd254;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_START        = 3'd1,
    EV_STOP         = 3'd2,
    EV_ADDR_WRITE   = 3'd3,
    EV_DATA_WRITTEN = 3'd4,
    EV_DATA_NEEDED  = 3'd5
  } event_e;

  typedef enum logic {
    CFG_TARGET_ADDRESS = 1'b0,
    CFG_ADDRESS_MASK   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic       last_sda;
    logic       last_scl;
    logic [3:0] bit_count;
    logic       address_phase;
    logic [7:0] shift_in;
    logic [7:0] received_byte;
    logic [7:0] send_byte;
    logic       drive_level;
    event_e     sticky;
    logic       reading;
  } state_t;

  typedef struct packed {
    logic       sda_drive;
    logic [7:0] rx_byte;
    event_e     event_code;
    logic       read_mode;
  } result_t;

  localparam state_t StateReset = '{
    last_sda:      1'b0,
    last_scl:      1'b1,
    bit_count:     BitsIdle,
    address_phase: 1'b0,
    shift_in:      8'd0,
    received_byte: 8'd0,
    send_byte:     8'd0,
    drive_level:   1'b0,
    sticky:        EV_NONE,
    reading:       1'b0
  };

endpackage

`default_nettype wire

FILE: hw/rtl/i2cbe_step.sv
// Next-state and result logic for one pin sample of the I2C target bit engine.
`default_nettype none

module i2cbe_step (
  input  i2cbe_pkg::state_t  state_i,
  input  logic [6:0]         target_address_i,
  input  logic [7:0]         address_mask_i,
  input  logic               scl_i,
  input  logic               sda_i,
  input  logic               tx_load_i,
  input  logic [7:0]         tx_data_i,
  input  logic               clear_status_i,
  output i2cbe_pkg::state_t  state_o,
  output i2cbe_pkg::result_t result_o
);

  always_comb begin
    i2cbe_pkg::state_t st;
    logic both_high;
    logic match;
    st        = state_i;
    both_high = 1'b0;
    match     = 1'b0;

    if (tx_load_i) begin
      st.send_byte = tx_data_i;
    end

    if ((sda_i != st.last_sda) || (scl_i != st.last_scl)) begin
      both_high = scl_i && st.last_scl;

      if (both_high && st.last_sda && !sda_i) begin
        st.bit_count     = 4'd0;
        st.address_phase = 1'b1;
        st.shift_in      = 8'd0;
        st.drive_level   = 1'b0;
        st.reading       = 1'b0;
        st.sticky        = i2cbe_pkg::EV_START;
      end
      if (both_high && !st.last_sda && sda_i) begin
        st.bit_count     = i2cbe_pkg::BitsIdle;
        st.address_phase = 1'b0;
        st.drive_level   = 1'b0;
        st.reading       = 1'b0;
        st.sticky        = i2cbe_pkg::EV_STOP;
      end

      // Rising SCL: sample a data bit, MSB first; on the ack clock the counter only advances.
      if ((st.bit_count < i2cbe_pkg::BitsDone) && !st.last_scl && scl_i) begin
        if (st.bit_count < i2cbe_pkg::BitsAck) begin
          st.shift_in[~st.bit_count[2:0]] = st.shift_in[~st.bit_count[2:0]] | sda_i;
        end
        st.bit_count = st.bit_count + 4'd1;
      end

      // Falling SCL in read mode: present the next transmit bit, or the ack level at the ack position.
      if ((st.bit_count < i2cbe_pkg::BitsDone) && st.last_scl && !scl_i && st.reading) begin
        if (st.bit_count < i2cbe_pkg::BitsAck) begin
          st.drive_level = st.send_byte[~st.bit_count[2:0]];
        end else begin
          st.drive_level = i2cbe_pkg::SdaAck;
        end
      end

      match = (st.shift_in & address_mask_i) == {target_address_i, 1'b0};

      if (st.bit_count == i2cbe_pkg::BitsAck) begin
        if (st.address_phase) begin
          st.drive_level = match ? i2cbe_pkg::SdaAck : i2cbe_pkg::SdaNack;
        end else if (!st.reading) begin
          st.drive_level = i2cbe_pkg::SdaAck;
        end
      end

      if (st.bit_count == i2cbe_pkg::BitsDone) begin
        if (st.address_phase && !match) begin
          st.bit_count     = i2cbe_pkg::BitsIdle;
          st.address_phase = 1'b0;
        end else begin
          if (st.address_phase) begin
            if (st.shift_in[0]) begin
              st.reading = 1'b1;
              st.sticky  = i2cbe_pkg::EV_DATA_NEEDED;
            end else begin
              st.sticky  = i2cbe_pkg::EV_ADDR_WRITE;
            end
          end else if (!st.reading) begin
            st.sticky = i2cbe_pkg::EV_DATA_WRITTEN;
          end else begin
            st.sticky = i2cbe_pkg::EV_DATA_NEEDED;
          end
          st.address_phase = 1'b0;
          st.received_byte = st.shift_in;
          st.bit_count     = 4'd0;
          st.shift_in      = 8'd0;
        end
      end

      st.last_sda = sda_i;
      st.last_scl = scl_i;
    end

    result_o.sda_drive  = st.drive_level;
    result_o.rx_byte    = st.received_byte;
    result_o.event_code = st.sticky;
    result_o.read_mode  = st.reading;

    if (clear_status_i) begin
      st.sticky = i2cbe_pkg::EV_NONE;
    end
    state_o = st;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_target_bit_engine.sv
// Top level of the I2C target bit engine: state, configuration and result register.
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        into       in_valid_i / in_ready_o  scl, sda, tx_load, tx_data, clear_status
// out       out of     out_valid_o / out_ready_i sda_drive, rx_byte, event_code, read_mode
// cfg       into       cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
// Each request is handled in one combinational pass: the sample is combined with the engine
// state and the result lands in the output register at the same edge as the new state.
// A new request is taken every cycle while the output register is empty or being drained,
// so a stall on the result side holds back the input side by exactly that one register.
// Reset returns the state and both configuration registers to their power-up values
// and empties the output register.

module i2c_target_bit_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       scl_i,
  input  logic       sda_i,
  input  logic       tx_load_i,
  input  logic [7:0] tx_data_i,
  input  logic       clear_status_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       sda_drive_o,
  output logic [7:0] rx_byte_o,
  output logic [2:0] event_code_o,
  output logic       read_mode_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  i2cbe_pkg::state_t  state_q, state_d;
  i2cbe_pkg::result_t result_q, result_d;
  logic               out_valid_q;
  logic [6:0]         target_address_q;
  logic [7:0]         address_mask_q;
  logic               in_fire;

  // The output register is free when empty or when its current result is being taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  i2cbe_step u_step (
    .state_i          (state_q),
    .target_address_i (target_address_q),
    .address_mask_i   (address_mask_q),
    .scl_i            (scl_i),
    .sda_i            (sda_i),
    .tx_load_i        (tx_load_i),
    .tx_data_i        (tx_data_i),
    .clear_status_i   (clear_status_i),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  // The user must issue configuration writes only while the engine is quiet; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_address_q <= i2cbe_pkg::TargetAddrReset;
      address_mask_q   <= i2cbe_pkg::AddrMaskReset;
    end else if (cfg_we_i) begin
      case (i2cbe_pkg::cfg_reg_e'(cfg_index_i))
        i2cbe_pkg::CFG_TARGET_ADDRESS: target_address_q <= cfg_data_i[6:0];
        i2cbe_pkg::CFG_ADDRESS_MASK:   address_mask_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2cbe_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sda_drive_o  = result_q.sda_drive;
  assign rx_byte_o    = result_q.rx_byte;
  assign event_code_o = result_q.event_code;
  assign read_mode_o  = result_q.read_mode;

  // The bit counter only ever rests on a data position, the ack position or idle.
  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.bit_count <= i2cbe_pkg::BitsAck) || (state_q.bit_count == i2cbe_pkg::BitsIdle))
    else $error("bit counter left its legal range");

  // Every accepted request leaves a result waiting in the output register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no result");

  // A clear request empties the sticky status once its result is captured.
  a_clear_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && clear_status_i) |=> (state_q.sticky == i2cbe_pkg::EV_NONE))
    else $error("sticky status not cleared on request");

  // A stop condition always leaves the engine idle and out of read mode.
  a_stop_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.last_scl && scl_i && !state_q.last_sda && sda_i)
      |=> ((state_q.bit_count == i2cbe_pkg::BitsIdle) && !state_q.reading))
    else $error("stop condition did not return the engine to idle");

endmodule

`default_nettype wire
